// ===== sv/pwr_pkg.sv =====
// Shared types, constants and helpers for the pulse width recorder.
package pwr_pkg;

    // Store geometry
    localparam int MAX_ENTRIES = 256;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int IDX_W       = $clog2(MAX_ENTRIES + 1);
    localparam int TIME_W      = 16;
    localparam int IDLE_W      = 6;

    // Register reset values and limits
    localparam logic [TIME_W-1:0] GAP_RESET = 16'd62500;
    localparam logic [IDLE_W-1:0] TMO_RESET = 6'd40;
    localparam logic [IDLE_W-1:0] IDLE_MAX  = 6'd63;

    // Item opcodes
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_ARM  = 2'd1,
        OP_READ = 2'd2
    } op_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_GAP     = 1'b0,
        REG_TIMEOUT = 1'b1
    } cfg_reg_t;

    // Reported status codes
    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_REC     = 2'd1,
        ST_DONE    = 2'd2,
        ST_TIMEOUT = 2'd3
    } status_t;

    // Recorder mode, one-hot
    typedef enum logic [3:0] {
        MODE_IDLE    = 4'b0001,
        MODE_REC     = 4'b0010,
        MODE_DONE    = 4'b0100,
        MODE_TIMEOUT = 4'b1000
    } mode_t;

    // Write request toward the two entry stores
    typedef struct packed {
        logic              first_we;
        logic              second_we;
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] data;
    } mem_wr_t;

    // Per-item result from the control logic
    typedef struct packed {
        status_t    status;
        logic [8:0] pulse_count;
    } ctrl_res_t;

    function automatic status_t mode_to_status(mode_t m);
        status_t s;
        unique case (m)
            MODE_IDLE:    s = ST_IDLE;
            MODE_REC:     s = ST_REC;
            MODE_DONE:    s = ST_DONE;
            MODE_TIMEOUT: s = ST_TIMEOUT;
            default:      s = ST_IDLE;
        endcase
        return s;
    endfunction

endpackage

// ===== sv/pulse_width_recorder.sv =====
// Top level of the infrared pulse width recorder: input stage, entry stores, output register.
// A result beat is registered after its item is accepted, first in stage 1 (control update
// and store read), then in the output register; a stall can hold it in either.
// Throughput: one item per cycle while the output is not stalled; the read of a store entry
// and a tick's write go to separate RAM ports, so neither limits the rate.
// Reset: control state, config registers and valid flags take their reset values at once;
// store contents are undefined until written.
module pulse_width_recorder (
    input  logic                    clk,
    input  logic                    rst_n,
    // slave stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [15:0]             s_tdata,  // [0] level, [8:1] read_index, rest zero
    input  logic [1:0]              s_tuser,  // [1:0] opcode
    // master stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [47:0]             m_tdata,  // [1:0] status, [10:2] pulse_count,
                                              // [26:11] first_time, [42:27] second_time
    // configuration write port
    input  logic                    cfg_we,
    input  pwr_pkg::cfg_reg_t       cfg_index,
    input  logic [15:0]             cfg_data
);
    import pwr_pkg::*;

    logic              accept;
    op_t               op;
    logic              level;
    logic [7:0]        read_index;
    logic              rd_hit;
    mem_wr_t           wr;
    ctrl_res_t         res;
    logic [TIME_W-1:0] first_rd;
    logic [TIME_W-1:0] second_rd;
    logic              advance;

    logic              s1_valid_reg, s1_valid_next;
    ctrl_res_t         s1_res_reg;
    logic              s1_rd_reg;
    logic              out_valid_reg, out_valid_next;
    logic [47:0]       out_data_reg;

    // Input beat decode
    assign op         = op_t'(s_tuser);
    assign level      = s_tdata[0];
    assign read_index = s_tdata[8:1];
    assign advance    = !out_valid_reg || m_tready;
    assign s_tready   = !s1_valid_reg || advance;
    assign accept     = s_tvalid && s_tready;
    assign rd_hit     = accept && (op == OP_READ) && (32'(read_index) < 32'(MAX_ENTRIES));

    pwr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .op        (op),
        .level     (level),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .wr        (wr),
        .res       (res)
    );

    // Entry stores
    pwr_ram #(.WIDTH(TIME_W), .DEPTH(MAX_ENTRIES)) u_first_ram (
        .clk   (clk),
        .we    (wr.first_we),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd_hit),
        .raddr (ADDR_W'(read_index)),
        .rdata (first_rd)
    );

    pwr_ram #(.WIDTH(TIME_W), .DEPTH(MAX_ENTRIES)) u_second_ram (
        .clk   (clk),
        .we    (wr.second_we),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd_hit),
        .raddr (ADDR_W'(read_index)),
        .rdata (second_rd)
    );

    // Valid flags of the two stages
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
            s1_valid_next  = accept;
        end
        else if (accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage 1 payload, waits on the store read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= res;
            s1_rd_reg  <= rd_hit;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            out_data_reg <= {5'd0,
                             s1_rd_reg ? second_rd : {TIME_W{1'b0}},
                             s1_rd_reg ? first_rd : {TIME_W{1'b0}},
                             s1_res_reg.pulse_count,
                             s1_res_reg.status};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== sv/pwr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pwr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read, held while idle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/pwr_ctrl.sv =====
// Recorder control: tick counter, entry index, period expiry and config registers.
module pwr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  pwr_pkg::op_t       op,
    input  logic               level,
    input  logic               cfg_we,
    input  pwr_pkg::cfg_reg_t  cfg_index,
    input  logic [15:0]        cfg_data,
    output pwr_pkg::mem_wr_t   wr,
    output pwr_pkg::ctrl_res_t res
);
    import pwr_pkg::*;

    logic [TIME_W-1:0] gap_reg;
    logic [IDLE_W-1:0] tmo_reg;
    mode_t             mode_reg, mode_next;
    logic [TIME_W-1:0] tick_reg, tick_next;
    logic [IDLE_W-1:0] idle_reg, idle_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  capt_reg, capt_next;
    logic              last_level_reg, last_level_next;

    logic              changed;
    logic              has_room;
    logic [TIME_W-1:0] tick_inc;
    logic [IDLE_W-1:0] idle_inc;

    assign changed  = (level != last_level_reg);
    assign has_room = (32'(idx_reg) < 32'(MAX_ENTRIES));
    assign tick_inc = tick_reg + 1'b1;
    assign idle_inc = (idle_reg != IDLE_MAX) ? (idle_reg + 1'b1) : idle_reg;

    // Next state for one accepted item
    always_comb
    begin
        mode_next       = mode_reg;
        tick_next       = tick_reg;
        idle_next       = idle_reg;
        idx_next        = idx_reg;
        capt_next       = capt_reg;
        last_level_next = last_level_reg;
        wr.first_we     = 1'b0;
        wr.second_we    = 1'b0;
        wr.addr         = idx_reg[ADDR_W-1:0];
        wr.data         = tick_reg;
        if (accept)
        begin
            unique case (op)
                OP_TICK:
                begin
                    last_level_next = level;
                    if (mode_reg == MODE_REC)
                    begin
                        if (changed)
                        begin
                            // level change: store count if there is room, clear counter
                            if (has_room)
                            begin
                                if (!level)
                                begin
                                    wr.first_we = 1'b1;
                                end
                                else
                                begin
                                    wr.second_we = 1'b1;
                                    idx_next     = idx_reg + 1'b1;
                                end
                            end
                            tick_next = '0;
                        end
                        else if (tick_inc == gap_reg)
                        begin
                            // period expiry
                            tick_next = '0;
                            idx_next  = '0;
                            if (idx_reg != '0)
                            begin
                                capt_next = idx_reg;
                                mode_next = MODE_DONE;
                            end
                            else
                            begin
                                idle_next = idle_inc;
                                if (idle_inc > tmo_reg)
                                begin
                                    mode_next = MODE_TIMEOUT;
                                end
                            end
                        end
                        else
                        begin
                            tick_next = tick_inc;
                        end
                    end
                end
                OP_ARM:
                begin
                    mode_next = MODE_REC;
                    tick_next = '0;
                    idle_next = '0;
                    idx_next  = '0;
                    capt_next = '0;
                end
                default:
                begin
                    // reads and unused codes leave the state alone
                end
            endcase
        end
    end

    // Result fields reflect the state after the item
    assign res.status      = mode_to_status(mode_next);
    assign res.pulse_count = (mode_next == MODE_DONE) ? 9'(capt_next) : 9'd0;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            tick_reg       <= '0;
            idle_reg       <= '0;
            idx_reg        <= '0;
            capt_reg       <= '0;
            last_level_reg <= 1'b1;
        end
        else
        begin
            mode_reg       <= mode_next;
            tick_reg       <= tick_next;
            idle_reg       <= idle_next;
            idx_reg        <= idx_next;
            capt_reg       <= capt_next;
            last_level_reg <= last_level_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg <= GAP_RESET;
            tmo_reg <= TMO_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAP:     gap_reg <= cfg_data;
                REG_TIMEOUT: tmo_reg <= cfg_data[IDLE_W-1:0];
                default:     ;
            endcase
        end
    end

endmodule
